[design/assert_macros.svh]
// Assertion macros used by stfs_block_address_translate.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that cons holds in the same cycle as ante
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that cons holds in the cycle after ante
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/stfs_bat_pkg.sv]
// Constants for the block address translator: spans, reciprocals, function codes,
// register map, quotient types. Depends on nothing.
`default_nettype none

package stfs_bat_pkg;

  localparam int unsigned BLOCK_SHIFT = 12;
  localparam logic [12:0] PAGE_BYTES = 13'h1000;

  localparam logic [7:0]  SPAN_L0 = 8'd170;
  localparam logic [14:0] SPAN_L1 = 15'd28900;
  localparam logic [22:0] SPAN_L2 = 23'd4913000;

  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [24:0] RECIP_L0 = 25'((64'h1_0000_0000) / SPAN_L0);
  localparam logic [17:0] RECIP_L1 = 18'((64'h1_0000_0000) / SPAN_L1);
  localparam logic [9:0]  RECIP_L2 = 10'((64'h1_0000_0000) / SPAN_L2);

  localparam logic [1:0] FUNC_DATA  = 2'd0;
  localparam logic [1:0] FUNC_HASH0 = 2'd1;
  localparam logic [1:0] FUNC_HASH1 = 2'd2;
  localparam logic [1:0] FUNC_HASH2 = 2'd3;

  localparam logic [1:0] REG_RO_FORMAT = 2'd0;
  localparam logic [1:0] REG_TOTAL     = 2'd1;
  localparam logic [1:0] REG_HEADER    = 2'd2;
  localparam logic [1:0] REG_PACKAGE   = 2'd3;

  typedef logic [16:0] quot_l0_t;
  typedef logic [9:0]  quot_l1_t;
  typedef logic [1:0]  quot_l2_t;

endpackage

`default_nettype wire

[design/stfs_block_address_translate.sv]
// Block address translator top level: five-stage pipeline and APB register file.
// Depends on stfs_bat_pkg and assert_macros.svh.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  input    | in_func, in_block_index                 | start high, busy low
//  result   | out_phys_block, out_byte_offset,        | out_valid strobe, 1 cycle
//           | out_ok                                  |
//  config   | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// One item per cycle; each result is registered in stages 1 to 4 and the result
// register and is on the ports while out_valid is high.
// The stages are the reciprocal multiply, quotient correction, address assembly,
// offset add and package bound compare.
// busy never rises; the pipeline has no stall.
// rst_n clears the valid bits and the registers to zero.
`default_nettype none

`include "assert_macros.svh"

module stfs_block_address_translate (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [23:0] in_block_index,
  output logic             out_valid,
  output logic [31:0]      out_phys_block,
  output logic [39:0]      out_byte_offset,
  output logic             out_ok,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  // registers
  logic        ro_r;
  logic [23:0] total_r;
  logic [31:0] header_r;
  logic [39:0] package_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ro_r      <= 1'b0;
      total_r   <= '0;
      header_r  <= '0;
      package_r <= '0;
    end else if (wr_en) begin
      case (paddr[4:3])
        stfs_bat_pkg::REG_RO_FORMAT: ro_r      <= pwdata[0];
        stfs_bat_pkg::REG_TOTAL:     total_r   <= pwdata[23:0];
        stfs_bat_pkg::REG_HEADER:    header_r  <= pwdata[31:0];
        stfs_bat_pkg::REG_PACKAGE:   package_r <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      stfs_bat_pkg::REG_RO_FORMAT: prdata = {63'd0, ro_r};
      stfs_bat_pkg::REG_TOTAL:     prdata = {40'd0, total_r};
      stfs_bat_pkg::REG_HEADER:    prdata = {32'd0, header_r};
      stfs_bat_pkg::REG_PACKAGE:   prdata = {24'd0, package_r};
      default:                     prdata = '0;
    endcase
  end

  // stage 1: reciprocal multiply
  logic                   v1_r;
  logic [1:0]             func1_r;
  logic [23:0]            idx1_r;
  logic                   inr1_r;
  stfs_bat_pkg::quot_l0_t qe0_r, qe0_nxt;
  stfs_bat_pkg::quot_l1_t qe1_r, qe1_nxt;
  stfs_bat_pkg::quot_l2_t qe2_r, qe2_nxt;
  logic [48:0]            prod0;
  logic [41:0]            prod1;
  logic [33:0]            prod2;

  assign prod0 = 49'(in_block_index) * 49'(stfs_bat_pkg::RECIP_L0);
  assign prod1 = 42'(in_block_index) * 42'(stfs_bat_pkg::RECIP_L1);
  assign prod2 = 34'(in_block_index) * 34'(stfs_bat_pkg::RECIP_L2);
  assign qe0_nxt = prod0[48:32];
  assign qe1_nxt = prod1[41:32];
  assign qe2_nxt = prod2[33:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    func1_r <= in_func;
    idx1_r  <= in_block_index;
    inr1_r  <= in_block_index < total_r;
    qe0_r   <= qe0_nxt;
    qe1_r   <= qe1_nxt;
    qe2_r   <= qe2_nxt;
  end

  // stage 2: correct the quotient estimates
  logic                   v2_r;
  logic [1:0]             func2_r;
  logic [23:0]            idx2_r;
  logic                   inr2_r;
  logic                   ge0_r, ge1_r;
  stfs_bat_pkg::quot_l0_t q0_r, q0_nxt;
  stfs_bat_pkg::quot_l1_t q1_r, q1_nxt;
  stfs_bat_pkg::quot_l2_t q2_r, q2_nxt;
  logic [24:0]            rem0, rem1, rem2;

  always_comb begin
    rem0 = {1'b0, idx1_r} - 25'(qe0_r) * 25'(stfs_bat_pkg::SPAN_L0);
    rem1 = {1'b0, idx1_r} - 25'(qe1_r) * 25'(stfs_bat_pkg::SPAN_L1);
    rem2 = {1'b0, idx1_r} - 25'(qe2_r) * 25'(stfs_bat_pkg::SPAN_L2);
    q0_nxt = (rem0 >= 25'(stfs_bat_pkg::SPAN_L0)) ? qe0_r + 17'd1 : qe0_r;
    q1_nxt = (rem1 >= 25'(stfs_bat_pkg::SPAN_L1)) ? qe1_r + 10'd1 : qe1_r;
    q2_nxt = (rem2 >= 25'(stfs_bat_pkg::SPAN_L2)) ? qe2_r + 2'd1 : qe2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    func2_r <= func1_r;
    idx2_r  <= idx1_r;
    inr2_r  <= inr1_r;
    ge0_r   <= idx1_r >= 24'(stfs_bat_pkg::SPAN_L0);
    ge1_r   <= idx1_r >= 24'(stfs_bat_pkg::SPAN_L1);
    q0_r    <= q0_nxt;
    q1_r    <= q1_nxt;
    q2_r    <= q2_nxt;
  end

  // stage 3: physical block number
  logic        v3_r;
  logic        ok3_r, ok3_nxt;
  logic [31:0] phys3_r, phys3_nxt;
  logic [31:0] t;
  logic [31:0] step0, step1;
  logic [31:0] lv0, lv1, lv2;
  logic [31:0] data_phys, hash0_phys, hash1_phys;

  always_comb begin
    t     = ro_r ? 32'd1 : 32'd2;
    step0 = 32'(stfs_bat_pkg::SPAN_L0) + t;
    step1 = 32'(stfs_bat_pkg::SPAN_L1) + (ro_r ? 32'd171 : 32'd342);
    lv0   = ro_r ? 32'(q0_r) + 32'd1 : (32'(q0_r) + 32'd1) << 1;
    lv1   = ro_r ? 32'(q1_r) + 32'd1 : (32'(q1_r) + 32'd1) << 1;
    lv2   = ro_r ? 32'(q2_r) + 32'd1 : (32'(q2_r) + 32'd1) << 1;
    data_phys = 32'(idx2_r) + lv0 + (ge0_r ? lv1 : 32'd0) + (ge1_r ? lv2 : 32'd0);
    hash0_phys = ge0_r ?
      32'(25'(q0_r) * 25'(step0[7:0])) + lv1 + (ge1_r ? t : 32'd0) : 32'd0;
    hash1_phys = ge1_r ? 32'(25'(q1_r) * 25'(step1[14:0])) + t : step0;
    case (func2_r)
      stfs_bat_pkg::FUNC_DATA:  phys3_nxt = data_phys;
      stfs_bat_pkg::FUNC_HASH0: phys3_nxt = hash0_phys;
      stfs_bat_pkg::FUNC_HASH1: phys3_nxt = hash1_phys;
      stfs_bat_pkg::FUNC_HASH2: phys3_nxt = step1;
      default:                  phys3_nxt = data_phys;
    endcase
    ok3_nxt = (func2_r != stfs_bat_pkg::FUNC_DATA) || inr2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    phys3_r <= phys3_nxt;
    ok3_r   <= ok3_nxt;
  end

  // stage 4: byte offset and block end
  logic        v4_r;
  logic        ok4_r;
  logic [31:0] phys4_r;
  logic [44:0] off4_r, off4_nxt;
  logic [45:0] end4_r, end4_nxt;
  logic [32:0] base;

  always_comb begin
    base = ({1'b0, header_r} + 33'(stfs_bat_pkg::PAGE_BYTES - 13'd1))
           & ~33'(stfs_bat_pkg::PAGE_BYTES - 13'd1);
    off4_nxt = 45'(base) + {1'b0, phys3_r, 12'd0};
    end4_nxt = 46'(base) + {1'b0, 33'(phys3_r) + 33'd1, 12'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    phys4_r <= phys3_r;
    off4_r  <= off4_nxt;
    end4_r  <= end4_nxt;
    ok4_r   <= ok3_r && (base != 33'd0);
  end

  // stage 5: package bound, result register
  logic ok5_nxt;

  assign ok5_nxt = ok4_r && (end4_r <= 46'(package_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    out_ok          <= ok5_nxt;
    out_phys_block  <= ok5_nxt ? phys4_r : 32'd0;
    out_byte_offset <= ok5_nxt ? off4_r[39:0] : 40'd0;
  end

  `ASSERT_NXT(a_valid_chain, clk, rst_n, v1_r, v2_r)
  `ASSERT_IMP(a_quot_exact, clk, rst_n, v2_r,
    (25'(q0_r) * 25'(stfs_bat_pkg::SPAN_L0) <= 25'(idx2_r)) &&
    (25'(idx2_r) - 25'(q0_r) * 25'(stfs_bat_pkg::SPAN_L0) < 25'(stfs_bat_pkg::SPAN_L0)))
  `ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && !out_ok,
    (out_phys_block == 32'd0) && (out_byte_offset == 40'd0))
  `ASSERT_IMP(a_ok_aligned, clk, rst_n, out_valid && out_ok,
    (out_byte_offset[11:0] == 12'd0) && (out_byte_offset != 40'd0))

endmodule

`default_nettype wire
